FILE: rtl/physical_memory_protection_unit_macros.svh
// Assertion macros for the checker file of the protection unit.
// Depends on nothing; included by the checker module.
`ifndef PHYSICAL_MEMORY_PROTECTION_UNIT_MACROS_SVH
`define PHYSICAL_MEMORY_PROTECTION_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PMP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Signal must never be high outside reset.
`define PMP_NEVER(lbl, clk, rstn, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(sig)) else $error(msg);
`endif

FILE: rtl/pmp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the protection unit.
// Depends on nothing; used by every module of the block.
package pmp_pkg;

  localparam int unsigned Entries   = 16;
  localparam int unsigned PaddrBits = 56;
  localparam int unsigned RawBits   = PaddrBits - 2;
  localparam int unsigned IdxBits   = (Entries > 1) ? $clog2(Entries) : 1;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_WCFG  = 2'd1;
  localparam logic [1:0] CMD_WADDR = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TOR   = 2'd1;
  localparam logic [1:0] MODE_NA4   = 2'd2;
  localparam logic [1:0] MODE_NAPOT = 2'd3;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_LOAD  = 2'd1;
  localparam logic [1:0] FAULT_STORE = 2'd2;
  localparam logic [1:0] FAULT_INSTR = 2'd3;

  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the command beat
    logic compare;  // run the range compare stage
    logic finish;   // form the result and update the table
  } pmp_ctrl_t;

  // Mask of the bytes covered below the NAPOT base, in raw address units.
  function automatic logic [RawBits-1:0] napot_mask(input logic [RawBits-1:0] raw);
    logic [RawBits-1:0] m;
    m = raw ^ (raw + RawBits'(1));
    return m >> 1;
  endfunction

endpackage

FILE: rtl/physical_memory_protection_unit.sv
`timescale 1ns / 1ps
// Channel   | Handshake          | Fields
// command   | start / busy       | cmd, entry_index, cfg_value, raw_address, phys_addr, ...
// result    | done_o strobe      | accepted_o, fault_code_o, fault_addr_o
// A command is captured into the beat registers at its accepting edge, the range compare
// over all entries is registered into hit_q, and the priority pick then forms the result
// in the result register, which raises the result strobe.
// Busy is high from the accepting edge until the strobe and drops with it, so the next
// command can be accepted at the edge that ends the strobe; none is taken while busy.
// Reset clears the entry table and the sequencer at once; the strobe cannot be stalled.
module physical_memory_protection_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  entry_index_i,
  input  logic [7:0]  cfg_value_i,
  input  logic [53:0] raw_address_i,
  input  logic [55:0] phys_addr_i,
  input  logic [6:0]  access_size_i,
  input  logic [1:0]  access_kind_i,
  input  logic [1:0]  priv_mode_i,
  input  logic [63:0] report_vaddr_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic [1:0]  fault_code_o,
  output logic [63:0] fault_addr_o
);

  pmp_pkg::pmp_ctrl_t ctrl;

  // Sequencer.
  pmp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // Table and decision logic.
  pmp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .cfg_value_i    (cfg_value_i),
    .raw_address_i  (raw_address_i),
    .phys_addr_i    (phys_addr_i),
    .access_size_i  (access_size_i),
    .access_kind_i  (access_kind_i),
    .priv_mode_i    (priv_mode_i),
    .report_vaddr_i (report_vaddr_i),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .fault_code_o   (fault_code_o),
    .fault_addr_o   (fault_addr_o)
  );

endmodule

FILE: rtl/pmp_ctrl.sv
`timescale 1ns / 1ps
// Controller of the protection unit: sequences the load, compare and finish
// steps of one command. Depends on pmp_pkg.
module pmp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output pmp_pkg::pmp_ctrl_t ctrl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state: idle, compare, finish, idle.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = S_CMP;
      S_CMP:  state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign ctrl_o.load    = (state_q == S_IDLE) && start;
  assign ctrl_o.compare = (state_q == S_CMP);
  assign ctrl_o.finish  = (state_q == S_FIN);

endmodule

FILE: rtl/pmp_dp.sv
`timescale 1ns / 1ps
// Datapath of the protection unit: entry table, range comparators, priority
// pick and result register. Depends on pmp_pkg.
module pmp_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pmp_pkg::pmp_ctrl_t           ctrl_i,
  input  logic [1:0]                   cmd_i,
  input  logic [5:0]                   entry_index_i,
  input  logic [7:0]                   cfg_value_i,
  input  logic [53:0]                  raw_address_i,
  input  logic [55:0]                  phys_addr_i,
  input  logic [6:0]                   access_size_i,
  input  logic [1:0]                   access_kind_i,
  input  logic [1:0]                   priv_mode_i,
  input  logic [63:0]                  report_vaddr_i,
  output logic                         done_o,
  output logic                         accepted_o,
  output logic [1:0]                   fault_code_o,
  output logic [63:0]                  fault_addr_o
);

  localparam int unsigned N  = pmp_pkg::Entries;
  localparam int unsigned RB = pmp_pkg::RawBits;
  localparam int unsigned AW = pmp_pkg::PaddrBits + 2;

  logic [7:0]    cfg_q [N];
  logic [RB-1:0] raw_q [N];

  // Captured command beat.
  logic [1:0]  cmd_q, kind_q, priv_q;
  logic [5:0]  idx_q;
  logic [7:0]  cval_q;
  logic [53:0] rawin_q;
  logic [55:0] addr_q;
  logic [6:0]  size_q;
  logic [63:0] vaddr_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_i;
      idx_q   <= entry_index_i;
      cval_q  <= cfg_value_i;
      rawin_q <= raw_address_i;
      addr_q  <= phys_addr_i;
      size_q  <= access_size_i;
      kind_q  <= access_kind_i;
      priv_q  <= priv_mode_i;
      vaddr_q <= report_vaddr_i;
    end
  end

  // Access bounds, two bits wider than the physical address so the last byte cannot wrap.
  logic [AW-1:0] first_w, last_w;
  assign first_w = AW'(addr_q);
  assign last_w  = first_w + ((size_q == 7'd0) ? AW'(0) : AW'(size_q - 7'd1));

  // Per-entry range comparators, one per entry, registered into hit_q.
  logic [N-1:0] hit_d, hit_q;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [AW-1:0] lo, hi;
      logic [RB-1:0] m;
      logic [1:0]    md;
      md = cfg_q[i][4:3];
      m  = pmp_pkg::napot_mask(raw_q[i]);
      lo = '0;
      hi = '0;
      hit_d[i] = 1'b0;
      case (md)
        pmp_pkg::MODE_TOR: begin
          lo = (i == 0) ? AW'(0) : {2'b00, raw_q[(i == 0) ? 0 : i - 1], 2'b00};
          hi = {2'b00, raw_q[i], 2'b00};
        end
        pmp_pkg::MODE_NA4: begin
          lo = {2'b00, raw_q[i], 2'b00};
          hi = lo + AW'(4);
        end
        pmp_pkg::MODE_NAPOT: begin
          lo = {2'b00, raw_q[i] & ~m, 2'b00};
          hi = lo + {1'b0, m, 3'b000} + AW'(8);
        end
        default: ;
      endcase
      if (md == pmp_pkg::MODE_NAPOT && raw_q[i] == '1) hit_d[i] = 1'b1;
      else if (md != pmp_pkg::MODE_OFF)
        hit_d[i] = (first_w >= lo) && (first_w < hi) && (last_w >= lo) && (last_w < hi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.compare) hit_q <= hit_d;
  end

  // Priority pick of the lowest hit and the check decision.
  logic          any_act, any_lock, machine, found, allow;
  logic [7:0]    pcfg;
  always_comb begin
    any_act  = 1'b0;
    any_lock = 1'b0;
    found    = 1'b0;
    pcfg     = '0;
    for (int i = 0; i < N; i++) begin
      if (cfg_q[i][4:3] != pmp_pkg::MODE_OFF) any_act = 1'b1;
      if (cfg_q[i][7]) any_lock = 1'b1;
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        found = 1'b1;
        pcfg  = cfg_q[i];
      end
    end
    machine = (priv_q == pmp_pkg::PRIV_MACHINE);
    if (!any_act || (machine && !any_lock)) allow = 1'b1;
    else if (!found) allow = machine;
    else if (machine && !pcfg[7]) allow = 1'b1;
    else begin
      case (kind_q)
        pmp_pkg::KIND_READ:  allow = pcfg[0];
        pmp_pkg::KIND_WRITE: allow = pcfg[1];
        pmp_pkg::KIND_FETCH: allow = pcfg[2];
        default:             allow = 1'b0;
      endcase
    end
  end

  // Write checks.
  logic in_rng, lk, blocked;
  logic [pmp_pkg::IdxBits-1:0] wi;
  always_comb begin
    in_rng  = (7'(idx_q) < 7'(N));
    wi      = idx_q[pmp_pkg::IdxBits-1:0];
    lk      = in_rng && cfg_q[wi][7];
    blocked = 1'b0;
    for (int i = 0; i < N - 1; i++) begin
      if (in_rng && wi == pmp_pkg::IdxBits'(i) && cfg_q[i + 1][7]
          && cfg_q[i + 1][4:3] == pmp_pkg::MODE_TOR) blocked = 1'b1;
    end
  end

  // Table update on the finish step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        cfg_q[i] <= '0;
        raw_q[i] <= '0;
      end
    end else if (ctrl_i.finish) begin
      case (cmd_q)
        pmp_pkg::CMD_WCFG:
          if (in_rng && !lk) cfg_q[wi] <= cval_q;
        pmp_pkg::CMD_WADDR:
          if (in_rng && !lk && !blocked) raw_q[wi] <= rawin_q[RB-1:0];
        pmp_pkg::CMD_CLEAR:
          for (int i = 0; i < N; i++) cfg_q[i] <= cfg_q[i] & 8'h67;
        default: ;
      endcase
    end
  end

  // Result register, shown for one cycle.
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= ctrl_i.finish;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      accepted_o   <= 1'b0;
      fault_code_o <= pmp_pkg::FAULT_NONE;
      fault_addr_o <= '0;
      case (cmd_q)
        pmp_pkg::CMD_CHECK:
          if (allow) accepted_o <= 1'b1;
          else begin
            fault_code_o <= (kind_q == pmp_pkg::KIND_READ)  ? pmp_pkg::FAULT_LOAD :
                            (kind_q == pmp_pkg::KIND_WRITE) ? pmp_pkg::FAULT_STORE :
                                                              pmp_pkg::FAULT_INSTR;
            fault_addr_o <= vaddr_q;
          end
        pmp_pkg::CMD_WCFG:  accepted_o <= in_rng && !lk;
        pmp_pkg::CMD_WADDR: accepted_o <= in_rng && !lk && !blocked;
        default:            accepted_o <= 1'b1;
      endcase
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/pmp_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the protection unit, bound to the top level.
// Depends on pmp_pkg and the assertion macro header.
`include "physical_memory_protection_unit_macros.svh"
module pmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        accepted_o,
  input logic [1:0]  fault_code_o,
  input logic [63:0] fault_addr_o
);

  // A granted result shows neither a fault code nor a fault address.
  logic granted_with_fault;
  assign granted_with_fault = done_o && accepted_o &&
                              (fault_code_o != pmp_pkg::FAULT_NONE || fault_addr_o != 64'd0);

  // A beat accepted yields a result strobe.
  `PMP_ASSERT(a_lat, clk_i, rst_ni, (start && !busy) |-> ##3 done_o, "missing result")
  // An accepted beat makes the block busy (it stays busy until the result is shown).
  `PMP_ASSERT(a_busy, clk_i, rst_ni, (start && !busy) |=> busy, "not busy after accept")
  // A granted result carries no fault.
  `PMP_NEVER(a_okf, clk_i, rst_ni, granted_with_fault, "fault on granted result")
  // Strobes never come back to back.
  `PMP_ASSERT(a_gap, clk_i, rst_ni, done_o |=> !done_o, "double strobe")

endmodule

bind physical_memory_protection_unit pmp_checker u_pmp_checker (.*);

FILE: sim/physical_memory_protection_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the protection unit: directed and random commands
// against a behavioural model of the entry table. Depends on pmp_pkg and the RTL.
module physical_memory_protection_unit_tb;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  idx;
    logic [7:0]  cfg;
    logic [53:0] raw;
    logic [55:0] paddr;
    logic [6:0]  size;
    logic [1:0]  kind;
    logic [1:0]  priv;
    logic [63:0] vaddr;
  } pmp_cmd_t;

  typedef struct {
    logic        ok;
    logic [1:0]  code;
    logic [63:0] addr;
  } pmp_verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        done_o, accepted_o;
  logic [1:0]  fault_code_o;
  logic [63:0] fault_addr_o;

  pmp_cmd_t     cur_cmd = '{default: '0};
  pmp_cmd_t     pending_cmds[$];
  pmp_verdict_t verdicts_due[$];

  // Model copy of the entry table.
  logic [7:0]  tbl_cfg[pmp_pkg::Entries];
  logic [53:0] tbl_raw[pmp_pkg::Entries];
  // Raw addresses as the generator last wrote them, to aim checks at ranges.
  logic [53:0] aim_raw[pmp_pkg::Entries];

  int  idle_pct = 0;
  bit  beat_taken = 1'b0;
  int  mismatches = 0;
  int  beats_in = 0, beats_out = 0, faults_seen = 0;
  longint cycles = 0;

  physical_memory_protection_unit dut (
    .clk_i, .rst_ni, .start, .busy,
    .cmd_i(cur_cmd.cmd), .entry_index_i(cur_cmd.idx), .cfg_value_i(cur_cmd.cfg),
    .raw_address_i(cur_cmd.raw), .phys_addr_i(cur_cmd.paddr),
    .access_size_i(cur_cmd.size), .access_kind_i(cur_cmd.kind),
    .priv_mode_i(cur_cmd.priv), .report_vaddr_i(cur_cmd.vaddr),
    .done_o, .accepted_o, .fault_code_o, .fault_addr_o
  );

  // Clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Does entry i hold every byte from first to last?
  function automatic bit region_holds(int i, logic [63:0] first, logic [63:0] last);
    logic [63:0] r, lo, hi;
    int t;
    r = 64'(tbl_raw[i]);
    case (tbl_cfg[i][4:3])
      pmp_pkg::MODE_TOR: begin
        lo = (i == 0) ? 64'd0 : 64'(tbl_raw[i-1]) << 2;
        hi = r << 2;
      end
      pmp_pkg::MODE_NA4: begin
        lo = r << 2;
        hi = lo + 64'd4;
      end
      pmp_pkg::MODE_NAPOT: begin
        if (tbl_raw[i] == '1) return 1'b1;
        t = 0;
        while (t < pmp_pkg::RawBits && r[t]) t++;
        lo = (r & ~((64'd1 << t) - 64'd1)) << 2;
        hi = lo + (64'd1 << (t + 3));
      end
      default: return 1'b0;
    endcase
    return first >= lo && first < hi && last >= lo && last < hi;
  endfunction

  function automatic bit access_allowed(pmp_cmd_t c);
    bit machine, any_active, any_lock;
    logic [63:0] last;
    logic [7:0] e;
    machine = (c.priv == pmp_pkg::PRIV_MACHINE);
    any_active = 1'b0;
    any_lock = 1'b0;
    for (int i = 0; i < pmp_pkg::Entries; i++) begin
      if (tbl_cfg[i][4:3] != pmp_pkg::MODE_OFF) any_active = 1'b1;
      if (tbl_cfg[i][7]) any_lock = 1'b1;
    end
    if (!any_active || (machine && !any_lock)) return 1'b1;
    last = 64'(c.paddr) + ((c.size == 0) ? 64'd0 : 64'(c.size) - 64'd1);
    for (int i = 0; i < pmp_pkg::Entries; i++) begin
      e = tbl_cfg[i];
      if (e[4:3] == pmp_pkg::MODE_OFF || !region_holds(i, 64'(c.paddr), last)) continue;
      if (machine && !e[7]) return 1'b1;
      case (c.kind)
        pmp_pkg::KIND_READ:  return e[0];
        pmp_pkg::KIND_WRITE: return e[1];
        pmp_pkg::KIND_FETCH: return e[2];
        default:             return 1'b0;
      endcase
    end
    return machine;
  endfunction

  // Works out the result of one command and updates the model table.
  function automatic pmp_verdict_t pmp_predict(pmp_cmd_t c);
    pmp_verdict_t v;
    bit blocked;
    v = '{ok: 1'b0, code: pmp_pkg::FAULT_NONE, addr: 64'd0};
    case (c.cmd)
      pmp_pkg::CMD_CHECK: begin
        if (access_allowed(c)) v.ok = 1'b1;
        else begin
          v.code = (c.kind == pmp_pkg::KIND_READ)  ? pmp_pkg::FAULT_LOAD :
                   (c.kind == pmp_pkg::KIND_WRITE) ? pmp_pkg::FAULT_STORE :
                                                     pmp_pkg::FAULT_INSTR;
          v.addr = c.vaddr;
        end
      end
      pmp_pkg::CMD_WCFG: begin
        if (c.idx < pmp_pkg::Entries && !tbl_cfg[c.idx][7]) begin
          tbl_cfg[c.idx] = c.cfg;
          v.ok = 1'b1;
        end
      end
      pmp_pkg::CMD_WADDR: begin
        if (c.idx < pmp_pkg::Entries && !tbl_cfg[c.idx][7]) begin
          blocked = (c.idx + 1 < pmp_pkg::Entries) && tbl_cfg[c.idx+1][7] &&
                    tbl_cfg[c.idx+1][4:3] == pmp_pkg::MODE_TOR;
          if (!blocked) begin
            tbl_raw[c.idx] = c.raw;
            v.ok = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < pmp_pkg::Entries; i++) tbl_cfg[i] = tbl_cfg[i] & 8'h67;
        v.ok = 1'b1;
      end
    endcase
    return v;
  endfunction

  // Command beat accepted: predict its result straight away.
  always @(posedge clk_i) begin
    if (rst_ni) cycles++;
    if (rst_ni && start && !busy) begin
      verdicts_due.push_back(pmp_predict(cur_cmd));
      beats_in++;
      beat_taken = 1'b1;
    end
  end

  // Driver: new beats presented on the falling edge, with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || beat_taken)) begin
      beat_taken = 1'b0;
      if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    pmp_verdict_t v;
    if (rst_ni && done_o) begin
      beats_out++;
      if (fault_code_o != pmp_pkg::FAULT_NONE) faults_seen++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        v = verdicts_due.pop_front();
        if (accepted_o !== v.ok || fault_code_o !== v.code || fault_addr_o !== v.addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at cycle %0d: expected ok=%0b code=%0d addr=%h,",
                      " got ok=%0b code=%0d addr=%h"},
                     cycles, v.ok, v.code, v.addr, accepted_o, fault_code_o, fault_addr_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("timeout with %0d results outstanding", verdicts_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic pmp_cmd_t noise_cmd();
    pmp_cmd_t c;
    c.cmd   = 2'($urandom);
    c.idx   = 6'($urandom);
    c.cfg   = 8'($urandom);
    c.raw   = {22'($urandom), $urandom};
    c.paddr = {24'($urandom), $urandom};
    c.size  = 7'($urandom);
    c.kind  = 2'($urandom);
    c.priv  = 2'($urandom);
    c.vaddr = {$urandom, $urandom};
    return c;
  endfunction

  function automatic pmp_cmd_t make_cmd(logic [1:0] op, int idx, logic [7:0] cfg,
                                        logic [53:0] raw, logic [55:0] paddr,
                                        int size, logic [1:0] kind, logic [1:0] priv);
    pmp_cmd_t c;
    c = noise_cmd();
    c.cmd = op; c.idx = 6'(idx); c.cfg = cfg; c.raw = raw;
    c.paddr = paddr; c.size = 7'(size); c.kind = kind; c.priv = priv;
    return c;
  endfunction

  // Well-formed random command: small address pool so checks land on entries.
  function automatic pmp_cmd_t shaped_cmd();
    pmp_cmd_t c;
    int r, e, t;
    c = noise_cmd();
    r = $urandom_range(99);
    if (r < 3) c.cmd = pmp_pkg::CMD_CLEAR;
    else if (r < 28) c.cmd = pmp_pkg::CMD_WCFG;
    else if (r < 48) c.cmd = pmp_pkg::CMD_WADDR;
    else c.cmd = pmp_pkg::CMD_CHECK;
    c.idx = ($urandom_range(9) == 0) ? 6'($urandom)
                                     : 6'($urandom_range(pmp_pkg::Entries - 1));
    if ($urandom_range(4) != 0) c.cfg[7] = 1'b0;
    c.cfg[6:5] = 2'($urandom);
    if (c.cmd == pmp_pkg::CMD_WADDR) begin
      t = $urandom_range(8);
      case ($urandom_range(5))
        0:       c.raw = '1;
        1:       c.raw = {22'($urandom), $urandom};
        default: c.raw = (54'($urandom_range(255)) << 4) | ((54'd1 << t) - 54'd1);
      endcase
      if (c.idx < pmp_pkg::Entries) aim_raw[c.idx] = c.raw;
    end
    if (c.cmd == pmp_pkg::CMD_CHECK) begin
      e = $urandom_range(pmp_pkg::Entries - 1);
      if ($urandom_range(7) != 0)
        c.paddr = (56'(aim_raw[e]) << 2) + 56'($urandom_range(64)) - 56'($urandom_range(16));
      c.size = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
      c.kind = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    end
    return c;
  endfunction

  task automatic run_phase(int pct, int count);
    idle_pct = pct;
    for (int k = 0; k < count; k++)
      pending_cmds.push_back(($urandom_range(9) == 0) ? noise_cmd() : shaped_cmd());
    // Sender holds off until the block has drained.
    wait (pending_cmds.size() == 0 && !start && verdicts_due.size() == 0);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < pmp_pkg::Entries; i++) begin
      tbl_cfg[i] = '0;
      tbl_raw[i] = '0;
      aim_raw[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: empty table, extremes, every mode, locks and special cases.
    idle_pct = 0;
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, '1, 64,
                                    pmp_pkg::KIND_READ, 2'd0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WADDR, 0, 0, 54'h100, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WCFG, 0, 8'h0B, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'h3FC, 4,
                                    pmp_pkg::KIND_READ, 2'd0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'h3FE, 4,
                                    pmp_pkg::KIND_WRITE, 2'd1));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'h10, 0,
                                    pmp_pkg::KIND_FETCH, 2'd0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WADDR, 1, 0, 54'h200, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WCFG, 1, 8'h15, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'h800, 4,
                                    pmp_pkg::KIND_FETCH, 2'd0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'h800, 4, 2'd3, 2'd0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WADDR, 2, 0, 54'h1F3, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WCFG, 2, 8'h9C, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'h7C0, 64,
                                    pmp_pkg::KIND_FETCH, 2'd3));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'hFFFFF, 1,
                                    pmp_pkg::KIND_READ, 2'd3));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WCFG, 2, 8'h00, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WCFG, 3, 8'h89, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WADDR, 2, 0, 54'h5, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WCFG, 63, 8'h1F, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WADDR, 16, 0, '1, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WADDR, 15, 0, '1, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_WCFG, 15, 8'hFF, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, '1, 64,
                                    pmp_pkg::KIND_WRITE, 2'd0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CLEAR, 0, 0, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(pmp_pkg::CMD_CHECK, 0, 0, 0, 56'h400, 8,
                                    pmp_pkg::KIND_READ, 2'd0));
    wait (pending_cmds.size() == 0 && !start && verdicts_due.size() == 0);
    repeat (3) @(posedge clk_i);

    run_phase(27, 200);
    run_phase(76, 200);
    run_phase(0, 200);

    repeat (10) @(posedge clk_i);
    $display("covered %0d commands, %0d results, %0d of them faults",
             beats_in, beats_out, faults_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
